// File: hw/rtl/asc_pkg.sv
// shared types, codes and constants for the alarm snooze controller
package asc_pkg;

  // default number of alarm slots
  localparam int ALARM_SLOTS_DEF = 6;
  // widest slot index over the supported slot counts (up to 16)
  localparam int SLOT_W = 4;
  // first one-time slot
  localparam int ONE_TIME_FIRST = 3;
  // ringing lasts this many seconds before auto snooze (or waiting, once the snooze limit is reached)
  localparam int RING_LIMIT = 60;
  localparam int SEC_PER_MIN = 60;
  // snooze second counter saturates here
  localparam logic [11:0] SNOOZE_SEC_MAX = 12'hfff;

  // register reset values
  localparam logic [5:0] SNOOZE_MIN_RST = 6'd5;
  localparam logic [3:0] SNOOZE_LIM_RST = 4'd3;

  // configuration register indexes
  localparam logic CFG_SNOOZE_MIN = 1'b0;
  localparam logic CFG_SNOOZE_LIM = 1'b1;

  // request codes
  localparam logic [1:0] REQ_CLOCK = 2'd0;
  localparam logic [1:0] REQ_SNOOZE = 2'd1;
  localparam logic [1:0] REQ_BACK = 2'd2;
  localparam logic [1:0] REQ_SLOT_WR = 2'd3;

  // mode codes
  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_RING = 2'd1;
  localparam logic [1:0] MODE_SNOOZE = 2'd2;

  // input beat
  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
    logic       buzzer_busy;
    logic [2:0] slot_number;
    logic [4:0] slot_hour;
    logic [5:0] slot_minute;
    logic       slot_enable;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [1:0] mode;
    logic       led_on;
    logic       start_melody;
    logic       stop_melody;
    logic       disable_valid;
    logic [1:0] disable_index;
    logic       open_menu;
    logic       pending_valid;
    logic [4:0] pending_hour;
    logic [5:0] pending_minute;
  } out_beat_t;

  // one alarm table entry as stored in memory
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
  } slot_time_t;

  // search result handed from the scanner to the control logic
  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] slot;
    slot_time_t        tm;
  } scan_res_t;

endpackage

// File: hw/rtl/alarm_snooze_controller_top.sv
// alarm snooze controller top level: control sequencer, alarm table and result register
//
//  channel | ports                         | beat
//  --------+-------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data   | one request (in_beat_t)
//  result  | out_valid, out_ready, out_data| one result per request
//  config  | cfg_we, cfg_index, cfg_wdata  | one register write, no wait
//
//  A clock reading with no alarm pending first searches the alarm table:
//  the search reads one table entry per cycle through the memory's read port.
//  Every other request goes straight to execution. One request is in work at a time.
//  A result waiting in the output register holds the finishing request back.
//  Reset is synchronous and clears all slot enables at once; no clearing pass.
module alarm_snooze_controller_top #(
  parameter int ALARM_SLOTS = asc_pkg::ALARM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  asc_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output asc_pkg::out_beat_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [5:0]          cfg_wdata
);

  localparam int AW = $clog2(ALARM_SLOTS);
  localparam int SW = asc_pkg::SLOT_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  asc_pkg::in_beat_t       req_r;
  logic [5:0]              snz_min_r;
  logic [3:0]              snz_lim_r;
  logic [1:0]              mode_r, mode_nxt;
  logic [ALARM_SLOTS-1:0]  en_r, en_nxt;
  logic                    nv_r, nv_nxt;
  asc_pkg::slot_time_t     next_r, next_nxt;
  logic                    one_r, one_nxt;
  logic [asc_pkg::SLOT_W-1:0] nslot_r, nslot_nxt;
  logic [5:0]              ring_r, ring_nxt;
  logic [11:0]             snz_sec_r, snz_sec_nxt;
  logic [3:0]              snz_cnt_r, snz_cnt_nxt;
  logic [5:0]              seen_r, seen_nxt;
  logic                    out_valid_r;
  asc_pkg::out_beat_t      out_r, res;

  logic                    accept, commit, scan_start;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  asc_pkg::slot_time_t     ram_wdata, ram_rdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  asc_pkg::scan_res_t      scan;
  logic [11:0]             snz_len;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign scan_start = accept && (in_data.req_type == asc_pkg::REQ_CLOCK) && !nv_r;
  assign commit     = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign snz_len    = 12'(snz_min_r) * 12'(asc_pkg::SEC_PER_MIN);

  // alarm table: hour and minute per slot, enables kept in flops
  asc_ram #(
    .WIDTH($bits(asc_pkg::slot_time_t)),
    .DEPTH(ALARM_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next-alarm search
  asc_scan #(
    .ALARM_SLOTS(ALARM_SLOTS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .now_hour  (in_data.now_hour),
    .now_minute(in_data.now_minute),
    .slot_en   (en_r),
    .rd_en     (ram_re),
    .rd_addr   (ram_raddr),
    .rd_data   (ram_rdata),
    .res       (scan)
  );

  // slot write goes to memory at commit
  assign ram_we    = commit && (req_r.req_type == asc_pkg::REQ_SLOT_WR) &&
                     (5'(req_r.slot_number) < 5'(ALARM_SLOTS));
  assign ram_waddr = AW'(req_r.slot_number);
  assign ram_wdata = '{hour: req_r.slot_hour, minute: req_r.slot_minute};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = scan_start ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        if (scan.done) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // request execution: mode changes, counters and result fields
  always_comb begin
    logic [5:0] ring_inc;
    logic [11:0] sec_inc;
    logic go_ring;
    logic [SW-1:0] slot_ext;
    ring_inc    = ring_r + 6'd1;
    sec_inc     = (snz_sec_r < asc_pkg::SNOOZE_SEC_MAX) ? snz_sec_r + 12'd1 : snz_sec_r;
    go_ring     = 1'b0;
    slot_ext    = SW'(nslot_r);
    mode_nxt    = mode_r;
    en_nxt      = en_r;
    nv_nxt      = nv_r;
    next_nxt    = next_r;
    one_nxt     = one_r;
    nslot_nxt   = nslot_r;
    ring_nxt    = ring_r;
    snz_sec_nxt = snz_sec_r;
    snz_cnt_nxt = snz_cnt_r;
    seen_nxt    = seen_r;
    res         = '0;

    // search result taken over as the pending alarm
    if ((state_r == ST_SCAN) && scan.done && scan.found) begin
      nv_nxt    = 1'b1;
      next_nxt  = scan.tm;
      one_nxt   = (SW'(scan.slot) >= SW'(asc_pkg::ONE_TIME_FIRST));
      nslot_nxt = scan.slot;
    end

    if (state_r == ST_EXEC) begin
      case (req_r.req_type)
        asc_pkg::REQ_CLOCK: begin
          if (mode_r == asc_pkg::MODE_RING) begin
            if (seen_r != req_r.now_second) begin
              seen_nxt         = req_r.now_second;
              res.start_melody = !req_r.buzzer_busy;
              ring_nxt         = ring_inc;
              if (ring_inc >= 6'(asc_pkg::RING_LIMIT)) begin
                res.stop_melody = 1'b1;
                if (snz_cnt_r >= snz_lim_r) begin
                  mode_nxt    = asc_pkg::MODE_WAIT;
                  snz_cnt_nxt = '0;
                  nv_nxt      = 1'b0;
                  one_nxt     = 1'b0;
                end else begin
                  mode_nxt    = asc_pkg::MODE_SNOOZE;
                  snz_cnt_nxt = snz_cnt_r + 4'd1;
                  snz_sec_nxt = '0;
                end
              end
            end
          end else if (mode_r == asc_pkg::MODE_WAIT) begin
            go_ring = nv_r && (next_r.hour == req_r.now_hour) &&
                      (next_r.minute == req_r.now_minute);
          end else if ((mode_r == asc_pkg::MODE_SNOOZE) && (seen_r != req_r.now_second)) begin
            seen_nxt    = req_r.now_second;
            snz_sec_nxt = sec_inc;
            go_ring     = (sec_inc >= snz_len);
          end
          // entering ringing drops the pending alarm and retires a one-time slot
          if (go_ring) begin
            mode_nxt = asc_pkg::MODE_RING;
            seen_nxt = req_r.now_second;
            ring_nxt = '0;
            nv_nxt   = 1'b0;
            if (one_r) begin
              en_nxt[AW'(nslot_r)] = 1'b0;
              res.disable_valid    = 1'b1;
              res.disable_index    = 2'(slot_ext - SW'(asc_pkg::ONE_TIME_FIRST));
              one_nxt              = 1'b0;
            end
          end
        end
        asc_pkg::REQ_SNOOZE: begin
          if (mode_r == asc_pkg::MODE_RING) begin
            mode_nxt        = asc_pkg::MODE_SNOOZE;
            snz_sec_nxt     = '0;
            res.stop_melody = 1'b1;
          end
        end
        asc_pkg::REQ_BACK: begin
          if ((mode_r == asc_pkg::MODE_RING) || (mode_r == asc_pkg::MODE_SNOOZE)) begin
            mode_nxt        = asc_pkg::MODE_WAIT;
            snz_cnt_nxt     = '0;
            nv_nxt          = 1'b0;
            one_nxt         = 1'b0;
            res.stop_melody = 1'b1;
          end else begin
            res.open_menu = 1'b1;
          end
        end
        asc_pkg::REQ_SLOT_WR: begin
          if (5'(req_r.slot_number) < 5'(ALARM_SLOTS)) begin
            en_nxt[AW'(req_r.slot_number)] = req_r.slot_enable;
            nv_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end

    res.mode           = mode_nxt;
    res.led_on         = (mode_nxt != asc_pkg::MODE_WAIT);
    res.pending_valid  = nv_nxt;
    res.pending_hour   = nv_nxt ? next_nxt.hour : 5'd0;
    res.pending_minute = nv_nxt ? next_nxt.minute : 6'd0;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snz_min_r <= asc_pkg::SNOOZE_MIN_RST;
      snz_lim_r <= asc_pkg::SNOOZE_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        asc_pkg::CFG_SNOOZE_MIN: snz_min_r <= cfg_wdata;
        asc_pkg::CFG_SNOOZE_LIM: snz_lim_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // controller state, updated in the search and at commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= asc_pkg::MODE_WAIT;
      en_r      <= '0;
      nv_r      <= 1'b0;
      next_r    <= '0;
      one_r     <= 1'b0;
      nslot_r   <= '0;
      ring_r    <= '0;
      snz_sec_r <= '0;
      snz_cnt_r <= '0;
      seen_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit || (state_r == ST_SCAN)) begin
        mode_r    <= mode_nxt;
        en_r      <= en_nxt;
        nv_r      <= nv_nxt;
        next_r    <= next_nxt;
        one_r     <= one_nxt;
        nslot_r   <= nslot_nxt;
        ring_r    <= ring_nxt;
        snz_sec_r <= snz_sec_nxt;
        snz_cnt_r <= snz_cnt_nxt;
        seen_r    <= seen_nxt;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/asc_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module asc_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/asc_scan.sv
// next-alarm search: walks the alarm table one slot per cycle
module asc_scan #(
  parameter int ALARM_SLOTS = asc_pkg::ALARM_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [4:0]                     now_hour,
  input  logic [5:0]                     now_minute,
  input  logic [ALARM_SLOTS-1:0]         slot_en,
  output logic                           rd_en,
  output logic [$clog2(ALARM_SLOTS)-1:0] rd_addr,
  input  asc_pkg::slot_time_t            rd_data,
  output asc_pkg::scan_res_t             res
);

  localparam int AW = $clog2(ALARM_SLOTS);
  localparam int CW = $clog2(ALARM_SLOTS + 1);

  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    chk_v_r;
  logic [AW-1:0]           chk_idx_r;
  logic                    done_r, done_nxt;
  logic                    found_r, found_nxt;
  logic [AW-1:0]           best_idx_r, best_idx_nxt;
  asc_pkg::slot_time_t     best_r, best_nxt;
  logic [4:0]              hr_r;
  logic [5:0]              mn_r;
  logic                    later, better;

  // read issue: one slot address per cycle
  assign rd_en   = busy_r && (cnt_r < CW'(ALARM_SLOTS));
  assign rd_addr = cnt_r[AW-1:0];

  // candidate compare on the returned entry
  always_comb begin
    later  = (rd_data.hour > hr_r) || ((rd_data.hour == hr_r) && (rd_data.minute > mn_r));
    better = !found_r || (rd_data.hour < best_r.hour) ||
             ((rd_data.hour == best_r.hour) && (rd_data.minute < best_r.minute));
    cnt_nxt      = cnt_r;
    busy_nxt     = busy_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    done_nxt     = 1'b0;
    if (start) begin
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
      found_nxt = 1'b0;
    end else begin
      if (rd_en) begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(ALARM_SLOTS - 1)) begin
          busy_nxt = 1'b0;
        end
      end
      if (chk_v_r) begin
        if (slot_en[chk_idx_r] && later && better) begin
          found_nxt    = 1'b1;
          best_idx_nxt = chk_idx_r;
          best_nxt     = rd_data;
        end
        done_nxt = (chk_idx_r == AW'(ALARM_SLOTS - 1));
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      busy_r  <= 1'b0;
      chk_v_r <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      busy_r  <= busy_nxt;
      chk_v_r <= rd_en && !start;
      done_r  <= done_nxt;
      found_r <= found_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk_idx_r  <= rd_addr;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    if (start) begin
      hr_r <= now_hour;
      mn_r <= now_minute;
    end
  end

  assign res.done  = done_r;
  assign res.found = found_r;
  assign res.slot  = asc_pkg::SLOT_W'(best_idx_r);
  assign res.tm    = best_r;

endmodule

// File: hw/rtl/asc_chk.sv
// port-level checker for the alarm snooze controller, bound to the top level
module asc_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input asc_pkg::out_beat_t out_data
);

  // lamp follows the mode
  a_led_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.led_on == (out_data.mode != asc_pkg::MODE_WAIT)))
    else $error("led_on does not match mode");

  // no pending alarm shows a zero time
  a_pend_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.pending_valid) |->
      (out_data.pending_hour == 5'd0) && (out_data.pending_minute == 6'd0))
    else $error("pending time not cleared");

  // a one-time slot is retired only as ringing starts
  a_dis_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.disable_valid) |->
      (out_data.mode == asc_pkg::MODE_RING) && !out_data.stop_melody)
    else $error("slot disabled outside ring entry");

  // menu request only from waiting, with neither melody pulse
  a_menu_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.open_menu) |->
      (out_data.mode == asc_pkg::MODE_WAIT) && !out_data.stop_melody &&
      !out_data.start_melody)
    else $error("menu request outside waiting");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result beat changed while stalled");

endmodule

bind alarm_snooze_controller_top asc_chk u_asc_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
